/* src/msea_pkg.sv */
// Shared types, command codes and decode helpers for the ModR/M and SIB
// effective-address core. No dependencies.
package msea_pkg;

    localparam logic [1:0] CMD_MODRM = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP32 = 3'd5;
    localparam logic [2:0] IDX_NONE  = 3'd4;

    typedef struct packed {
        logic        is_write;
        logic        rm_is_register;
        logic [3:0]  reg_number;
        logic [3:0]  rm_number;
        logic        status;
        logic [2:0]  operand_length;
        logic        base_en;
        logic [3:0]  base_idx;
        logic        index_en;
        logic [3:0]  index_idx;
        logic [1:0]  scale;
        logic        rip_en;
        logic [31:0] disp;
        logic [63:0] value;
    } job_t;

    function automatic logic [2:0] disp_len(input logic [1:0] md, input logic [2:0] rm,
                                            input logic [2:0] sib_base);
        logic [2:0] len;
        len = 3'd0;
        case (md)
            2'd1: len = 3'd1;
            2'd2: len = 3'd4;
            2'd0:
            begin
                if (rm == RM_DISP32 || (rm == RM_SIB && sib_base == RM_DISP32))
                    len = 3'd4;
            end
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

/* src/msea_front.sv */
// Byte parser: latches ModR/M, SIB and displacement bytes and classifies the
// finished operand into a job for the back end. Depends on msea_pkg.
module msea_front
    import msea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        rex_r_bit,
    input  logic        rex_x_bit,
    input  logic        rex_b_bit,
    input  logic        addr32_flag,
    input  logic [63:0] rip_value,
    input  logic [3:0]  write_index,
    input  logic [63:0] write_value,
    output logic        push,
    output job_t        job
);

    typedef enum logic [1:0] {PH_IDLE, PH_SIB, PH_DISP} phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [7:0]  sib_reg, sib_next;
    logic [31:0] disp_reg, disp_next;
    logic [2:0]  rem_reg, rem_next;
    logic [3:0]  prefix_reg, prefix_next;
    logic        done;
    logic [1:0]  pos;
    logic [1:0]  md;
    logic [2:0]  rm;
    logic [2:0]  dl;
    logic        mem;

    always_comb
    begin
        phase_next  = phase_reg;
        modrm_next  = modrm_reg;
        sib_next    = sib_reg;
        disp_next   = disp_reg;
        rem_next    = rem_reg;
        prefix_next = prefix_reg;
        done        = 1'b0;
        pos = 2'(disp_len(modrm_reg[7:6], modrm_reg[2:0], sib_reg[2:0]) - rem_reg);
        case (command)
            CMD_MODRM:
            begin
                modrm_next  = data_byte;
                sib_next    = 8'd0;
                disp_next   = 32'd0;
                prefix_next = {addr32_flag, rex_r_bit, rex_x_bit, rex_b_bit};
                if (data_byte[7:6] == MOD_REG)
                    done = 1'b1;
                else if (data_byte[2:0] == RM_SIB)
                    phase_next = PH_SIB;
                else
                begin
                    rem_next = disp_len(data_byte[7:6], data_byte[2:0], 3'd0);
                    if (rem_next == 3'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_DISP;
                end
            end
            CMD_BYTE:
            begin
                if (phase_reg == PH_SIB)
                begin
                    sib_next = data_byte;
                    rem_next = disp_len(modrm_reg[7:6], modrm_reg[2:0], data_byte[2:0]);
                    if (rem_next == 3'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_DISP;
                end
                else if (phase_reg == PH_DISP)
                begin
                    disp_next[{pos, 3'b000} +: 8] = data_byte;
                    rem_next = rem_reg - 3'd1;
                    if (rem_next == 3'd0)
                        done = 1'b1;
                end
            end
            default: ;
        endcase
        if (done)
        begin
            phase_next = PH_IDLE;
            rem_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            modrm_reg  <= 8'd0;
            sib_reg    <= 8'd0;
            disp_reg   <= 32'd0;
            rem_reg    <= 3'd0;
            prefix_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            modrm_reg  <= modrm_next;
            sib_reg    <= sib_next;
            disp_reg   <= disp_next;
            rem_reg    <= rem_next;
            prefix_reg <= prefix_next;
        end
    end

    assign md  = modrm_next[7:6];
    assign rm  = modrm_next[2:0];
    assign dl  = disp_len(md, rm, sib_next[2:0]);
    assign mem = (md != MOD_REG) && !prefix_next[3];

    assign push = accept && (done || command == CMD_WRITE);

    always_comb
    begin
        job = '0;
        if (command == CMD_WRITE)
        begin
            job.is_write = 1'b1;
            job.base_idx = write_index;
            job.value    = write_value;
        end
        else
        begin
            job.rm_is_register = (md == MOD_REG);
            job.reg_number     = {prefix_next[2], modrm_next[5:3]};
            job.rm_number      = (md == MOD_REG) ? {prefix_next[0], rm} : 4'd0;
            job.status         = prefix_next[3];
            job.operand_length = 3'd1 + {2'd0, (md != MOD_REG && rm == RM_SIB)}
                               + ((md != MOD_REG) ? dl : 3'd0);
            job.rip_en   = mem && md == MOD_NODISP && rm == RM_DISP32;
            job.base_en  = mem && !(md == MOD_NODISP && rm == RM_DISP32)
                         && !(md == MOD_NODISP && rm == RM_SIB && sib_next[2:0] == RM_DISP32);
            job.base_idx = (rm == RM_SIB) ? {prefix_next[0], sib_next[2:0]}
                                          : {prefix_next[0], rm};
            job.index_en  = mem && rm == RM_SIB
                          && !(!prefix_next[1] && sib_next[5:3] == IDX_NONE);
            job.index_idx = {prefix_next[1], sib_next[5:3]};
            job.scale     = sib_next[7:6];
            if (!mem)
                job.disp = 32'd0;
            else if (md == MOD_DISP8)
                job.disp = {{24{disp_next[7]}}, disp_next[7:0]};
            else
                job.disp = disp_next;
            job.value = rip_value;
        end
    end

endmodule

/* src/msea_queue.sv */
// Two-entry job queue between parser and address back end.
// Depends on msea_pkg for the job type.
module msea_queue
    import msea_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* src/msea_back.sv */
// Address back end: register file, operand read stage, base plus scaled index
// stage and result register. Depends on msea_pkg.
module msea_back
    import msea_pkg::*;
#(
    parameter int NUM_REGS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        rm_is_register,
    output logic [3:0]  reg_number,
    output logic [3:0]  rm_number,
    output logic [63:0] effective_address,
    output logic        status,
    output logic [2:0]  operand_length
);

    localparam int IdxW = $clog2(NUM_REGS);

    logic [63:0]         rf_reg [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;

    logic        adv;
    logic        a_valid_reg;
    job_t        a_job_reg;
    logic [63:0] a_base_reg;
    logic [63:0] a_index_reg;
    logic        b_valid_reg;
    job_t        b_job_reg;
    logic [63:0] b_sum_reg;
    logic [63:0] sum_next;
    logic [63:0] ea_next;
    logic [IdxW-1:0] wr_idx;
    logic [IdxW-1:0] base_idx;
    logic [IdxW-1:0] index_idx;

    assign adv = !result_valid || !result_stall;
    assign pop = adv && !empty;

    assign wr_idx    = head.base_idx[IdxW-1:0];
    assign base_idx  = head.base_idx[IdxW-1:0];
    assign index_idx = head.index_idx[IdxW-1:0];

    always_ff @(posedge clk)
    begin
        if (pop && head.is_write)
            rf_reg[wr_idx] <= head.value;
        if (pop)
        begin
            a_job_reg   <= head;
            a_base_reg  <= rf_valid_reg[base_idx] ? rf_reg[base_idx] : 64'd0;
            a_index_reg <= rf_valid_reg[index_idx] ? rf_reg[index_idx] : 64'd0;
        end
    end

    always_comb
    begin
        sum_next = 64'd0;
        if (a_job_reg.rip_en)
            sum_next = a_job_reg.value;
        else if (a_job_reg.base_en)
            sum_next = a_base_reg;
        if (a_job_reg.index_en)
            sum_next = sum_next + (a_index_reg << a_job_reg.scale);
    end

    assign ea_next = b_sum_reg + {{32{b_job_reg.disp[31]}}, b_job_reg.disp};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_job_reg         <= a_job_reg;
            b_sum_reg         <= sum_next;
            rm_is_register    <= b_job_reg.rm_is_register;
            reg_number        <= b_job_reg.reg_number;
            rm_number         <= b_job_reg.rm_number;
            effective_address <= ea_next;
            status            <= b_job_reg.status;
            operand_length    <= b_job_reg.operand_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (pop && head.is_write)
                rf_valid_reg[wr_idx] <= 1'b1;
            if (adv)
            begin
                a_valid_reg  <= pop && !head.is_write;
                b_valid_reg  <= a_valid_reg;
                result_valid <= b_valid_reg;
            end
        end
    end

    a_no_write_in_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> !a_job_reg.is_write)
        else $error("register write entered address pipeline");

    a_regdirect_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rm_is_register) |-> (effective_address == 64'd0))
        else $error("register-direct beat carries nonzero address");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (effective_address == 64'd0 && rm_number == 4'd0
                                      || rm_is_register))
        else $error("unsupported beat carries an address");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (operand_length != 3'd0 && operand_length != 3'd7))
        else $error("operand length out of range");

endmodule

/* src/modrm_sib_effective_address_core.sv */
// ModR/M and SIB effective-address core: one byte or register write per beat.
// Results pass through the job queue, operand read, sum and result registers.
// Throughput: one input beat and one result beat per cycle when unstalled.
// Reset clears the parser, the job queue, the pipeline valids and the register
// file valid bits, so every register reads as zero until written.
// Depends on msea_pkg, msea_front, msea_queue and msea_back.
module modrm_sib_effective_address_core
    import msea_pkg::*;
#(
    parameter int NUM_REGS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        rex_r_bit,
    input  logic        rex_x_bit,
    input  logic        rex_b_bit,
    input  logic        addr32_flag,
    input  logic [63:0] rip_value,
    input  logic [3:0]  write_index,
    input  logic [63:0] write_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        rm_is_register,
    output logic [3:0]  reg_number,
    output logic [3:0]  rm_number,
    output logic [63:0] effective_address,
    output logic        status,
    output logic [2:0]  operand_length
);

    logic accept;
    logic push;
    job_t push_job;
    job_t head;
    logic full;
    logic empty;
    logic pop;

    assign item_stall = full;
    assign accept     = item_valid && !item_stall;

    msea_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .data_byte   (data_byte),
        .rex_r_bit   (rex_r_bit),
        .rex_x_bit   (rex_x_bit),
        .rex_b_bit   (rex_b_bit),
        .addr32_flag (addr32_flag),
        .rip_value   (rip_value),
        .write_index (write_index),
        .write_value (write_value),
        .push        (push),
        .job         (push_job)
    );

    msea_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    msea_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .empty             (empty),
        .pop               (pop),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .rm_is_register    (rm_is_register),
        .reg_number        (reg_number),
        .rm_number         (rm_number),
        .effective_address (effective_address),
        .status            (status),
        .operand_length    (operand_length)
    );

endmodule
